// ===== hdl/block_buffer_cache_table_top_assert.svh =====
// Assertion macros for the buffer cache table.
// Included by the top level; needs clk and rst_n in the including scope.
`ifndef BLOCK_BUFFER_CACHE_TABLE_TOP_ASSERT_SVH
`define BLOCK_BUFFER_CACHE_TABLE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define BBCT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BBCT_ASSERT_ONEHOT0(label, vec, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(vec)) else $error(msg);
`else
`define BBCT_ASSERT(label, prop, msg)
`define BBCT_ASSERT_ONEHOT0(label, vec, msg)
`endif
`endif

// ===== hdl/bbct_pkg.sv =====
// Shared types and codes for the buffer cache table.
// No dependencies.
package bbct_pkg;

    localparam int DEF_ENTRIES = 32;

    localparam logic [1:0] CMD_GET     = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_PIN     = 2'd2;
    localparam logic [1:0] CMD_UNPIN   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFREE = 2'd1;
    localparam logic [1:0] ST_UNDER  = 2'd2;
    localparam logic [1:0] ST_SAT    = 2'd3;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_UPD
    } state_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  device;
        logic [31:0] block_number;
        logic [4:0]  slot;
    } req_t;

    typedef struct packed {
        logic look;     // capture priority picks
        logic upd;      // apply the update to the selected cell
        logic is_get;
        logic use_hit;  // a tag match was seen in the lookup cycle
    } ctl_t;

    // Passed from each cell to the next higher one
    typedef struct packed {
        logic       match_seen;
        logic       free_seen;
        logic [7:0] count;
        logic       valid;
    } link_t;

endpackage

// ===== hdl/bbct_cell.sv =====
// One buffer entry of the cache table: tag, valid mark and reference count.
// Depends on bbct_pkg.
module bbct_cell #(
    parameter int IW       = 5,
    parameter int CELL_IDX = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  bbct_pkg::req_t req,
    input  bbct_pkg::ctl_t ctl,
    input  bbct_pkg::link_t link_in,
    input  logic [IW-1:0]  idx_in,
    output bbct_pkg::link_t link_out,
    output logic [IW-1:0]  idx_out,
    output logic           sel
);
    import bbct_pkg::*;

    logic [7:0]  dev_reg, dev_next;
    logic [31:0] blk_reg, blk_next;
    logic        valid_reg, valid_next;
    logic [7:0]  count_reg, count_next;
    logic        hsel_reg, hsel_next;
    logic        fsel_reg, fsel_next;
    logic        match;
    logic        free;
    logic        slot_hit;

    always_comb
    begin
        match    = (dev_reg == req.device) && (blk_reg == req.block_number);
        free     = (count_reg == 8'd0);
        slot_hit = ({4'b0, req.slot} == 9'(CELL_IDX));
        if (ctl.is_get)
        begin
            sel = ctl.use_hit ? hsel_reg : fsel_reg;
        end
        else
        begin
            sel = slot_hit;
        end
        link_out.match_seen = link_in.match_seen | match;
        link_out.free_seen  = link_in.free_seen | free;
        link_out.count      = link_in.count | (sel ? count_reg : 8'd0);
        link_out.valid      = link_in.valid | (sel & valid_reg);
        idx_out             = idx_in | (sel ? IW'(CELL_IDX) : '0);
    end

    always_comb
    begin
        dev_next   = dev_reg;
        blk_next   = blk_reg;
        valid_next = valid_reg;
        count_next = count_reg;
        hsel_next  = hsel_reg;
        fsel_next  = fsel_reg;
        if (ctl.look)
        begin
            // lowest index wins: only pick when nothing below has
            hsel_next = match && !link_in.match_seen;
            fsel_next = free && !link_in.free_seen;
        end
        if (ctl.upd && sel)
        begin
            case (req.cmd) inside
                CMD_GET:
                begin
                    valid_next = 1'b1;
                    if (ctl.use_hit)
                    begin
                        if (count_reg != COUNT_MAX)
                        begin
                            count_next = count_reg + 8'd1;
                        end
                    end
                    else
                    begin
                        dev_next   = req.device;
                        blk_next   = req.block_number;
                        count_next = 8'd1;
                    end
                end
                CMD_PIN:
                begin
                    if (count_reg != COUNT_MAX)
                    begin
                        count_next = count_reg + 8'd1;
                    end
                end
                CMD_RELEASE, CMD_UNPIN:
                begin
                    if (count_reg != 8'd0)
                    begin
                        count_next = count_reg - 8'd1;
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_reg   <= '0;
            blk_reg   <= '0;
            valid_reg <= 1'b0;
            count_reg <= '0;
            hsel_reg  <= 1'b0;
            fsel_reg  <= 1'b0;
        end
        else
        begin
            dev_reg   <= dev_next;
            blk_reg   <= blk_next;
            valid_reg <= valid_next;
            count_reg <= count_next;
            hsel_reg  <= hsel_next;
            fsel_reg  <= fsel_next;
        end
    end

endmodule

// ===== hdl/block_buffer_cache_table_top.sv =====
// Top level of the buffer cache table: request register, control FSM,
// cell chain and result register. Depends on bbct_pkg, bbct_cell and the assert header.
`include "block_buffer_cache_table_top_assert.svh"

// A request is handled in steps: the beat is registered, the lookup state
// compares the tag in every cell and ripples the lowest-index match and free
// picks along the cell chain, and the update state updates the chosen cell and
// loads the result register. Input is stalled during the lookup and update;
// a waiting result does not block the next beat, but the update cycle holds
// while the previous result is still stalled. Reset clears every entry at once.
module block_buffer_cache_table_top #(
    parameter int ENTRIES = bbct_pkg::DEF_ENTRIES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  device,
    input  logic [31:0] block_number,
    input  logic [4:0]  slot,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  slot_out,
    output logic        hit,
    output logic        needs_read,
    output logic [1:0]  status
);
    import bbct_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    state_t        state_reg, state_next;
    req_t          req_reg;
    logic          use_hit_reg, use_hit_next;
    logic          out_valid_reg, out_valid_next;
    logic [4:0]    slot_out_reg, slot_out_next;
    logic          hit_reg, hit_next;
    logic          needs_read_reg, needs_read_next;
    logic [1:0]    status_reg, status_next;
    ctl_t          ctl;
    logic          out_room;
    logic          in_range;
    logic [IW+4:0] idx_wide;

    link_t         links [ENTRIES+1];
    logic [IW-1:0] idxs  [ENTRIES+1];
    logic [ENTRIES-1:0] sel_vec;

    assign links[0] = '0;
    assign idxs[0]  = '0;

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        bbct_cell #(
            .IW       (IW),
            .CELL_IDX (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .req      (req_reg),
            .ctl      (ctl),
            .link_in  (links[g]),
            .idx_in   (idxs[g]),
            .link_out (links[g+1]),
            .idx_out  (idxs[g+1]),
            .sel      (sel_vec[g])
        );
    end

    assign out_room = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (out_room)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        in_stall    = 1'b1;
        ctl.look    = 1'b0;
        ctl.upd     = 1'b0;
        ctl.is_get  = (req_reg.cmd == CMD_GET);
        ctl.use_hit = use_hit_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
            end
            S_LOOK:
            begin
                ctl.look = 1'b1;
            end
            S_UPD:
            begin
                ctl.upd = out_room;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // result assembly from the chain head
    always_comb
    begin
        idx_wide        = {5'b0, idxs[ENTRIES]};
        in_range        = ({4'b0, req_reg.slot} < 9'(ENTRIES));
        use_hit_next    = ctl.look ? links[ENTRIES].match_seen : use_hit_reg;
        out_valid_next  = out_valid_reg && out_stall;
        slot_out_next   = slot_out_reg;
        hit_next        = hit_reg;
        needs_read_next = needs_read_reg;
        status_next     = status_reg;
        if (ctl.upd)
        begin
            out_valid_next  = 1'b1;
            slot_out_next   = idx_wide[4:0];
            hit_next        = 1'b0;
            needs_read_next = 1'b0;
            status_next     = ST_OK;
            if (ctl.is_get)
            begin
                if (use_hit_reg)
                begin
                    hit_next        = 1'b1;
                    needs_read_next = !links[ENTRIES].valid;
                    if (links[ENTRIES].count == COUNT_MAX)
                    begin
                        status_next = ST_SAT;
                    end
                end
                else if (sel_vec != '0)
                begin
                    needs_read_next = 1'b1;
                end
                else
                begin
                    slot_out_next = 5'd0;
                    status_next   = ST_NOFREE;
                end
            end
            else
            begin
                slot_out_next = req_reg.slot;
                if (in_range)
                begin
                    if (req_reg.cmd == CMD_PIN)
                    begin
                        if (links[ENTRIES].count == COUNT_MAX)
                        begin
                            status_next = ST_SAT;
                        end
                    end
                    else if (links[ENTRIES].count == 8'd0)
                    begin
                        status_next = ST_UNDER;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            use_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            req_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            use_hit_reg   <= use_hit_next;
            out_valid_reg <= out_valid_next;
            if (in_valid && !in_stall)
            begin
                req_reg <= '{cmd: cmd, device: device, block_number: block_number, slot: slot};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot_out_reg   <= slot_out_next;
        hit_reg        <= hit_next;
        needs_read_reg <= needs_read_next;
        status_reg     <= status_next;
    end

    assign out_valid  = out_valid_reg;
    assign slot_out   = slot_out_reg;
    assign hit        = hit_reg;
    assign needs_read = needs_read_reg;
    assign status     = status_reg;

    `BBCT_ASSERT(a_accept_to_look, (in_valid && !in_stall) |=> (state_reg == S_LOOK), "accepted beat did not start a lookup")
    `BBCT_ASSERT_ONEHOT0(a_one_cell_sel, sel_vec, "more than one cell selected")
    `BBCT_ASSERT(a_result_from_update, $rose(out_valid) |-> $past(state_reg == S_UPD), "result appeared without an update cycle")
    `BBCT_ASSERT(a_nofree_clean, (out_valid && status == ST_NOFREE) |-> (!hit && !needs_read && slot_out == 5'd0), "no-free result carries slot data")

endmodule

// ===== test/tb_block_buffer_cache_table_top.sv =====
`timescale 1ns / 1ps
// Testbench for block_buffer_cache_table_top: directed and random get, release, pin and
// unpin beats, each result checked against a table predictor kept in this file.
// Depends on bbct_pkg and the top-level RTL.
module tb_block_buffer_cache_table_top;
    import bbct_pkg::*;

    localparam int ENTRIES     = DEF_ENTRIES;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_LEN    = 120;
    localparam int QUIET_FROM  = 900;
    localparam int QUIET_TO    = 1250;
    localparam int MAX_PRINTS  = 40;

    typedef struct packed {
        logic [4:0] slot_out;
        logic       hit;
        logic       needs_read;
        logic [1:0] status;
    } grant_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd          = CMD_GET;
    logic [7:0]  device       = '0;
    logic [31:0] block_number = '0;
    logic [4:0]  slot         = '0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [4:0]  slot_out;
    logic        hit;
    logic        needs_read;
    logic [1:0]  status;

    // predicted table contents
    logic [7:0]  tag_dev   [ENTRIES];
    logic [31:0] tag_blk   [ENTRIES];
    logic        tag_valid [ENTRIES];
    logic [7:0]  ref_cnt   [ENTRIES];

    req_t   pending_reqs[$];
    grant_t expected_grants[$];
    req_t   next_req;
    grant_t want;

    int n_queued   = 0;
    int n_accepted = 0;
    int n_checked  = 0;
    int n_errors   = 0;
    int cycles     = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;
    int n_hits     = 0;
    int n_nofree   = 0;
    int n_sat      = 0;
    int n_under    = 0;
    logic quiet;

    assign quiet = (n_accepted >= QUIET_FROM) && (n_accepted < QUIET_TO);

    block_buffer_cache_table_top #(.ENTRIES(ENTRIES)) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .device       (device),
        .block_number (block_number),
        .slot         (slot),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .slot_out     (slot_out),
        .hit          (hit),
        .needs_read   (needs_read),
        .status       (status)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
        if (n_errors < MAX_PRINTS)
            $display("MISMATCH beat %0d: %s got %0d expected %0d", n_checked, what, got, exp_val);
        n_errors++;
    endtask

    task automatic push_req(logic [1:0] op, logic [7:0] dev, logic [31:0] blk, logic [4:0] idx);
        req_t rq;
        rq.cmd          = op;
        rq.device       = dev;
        rq.block_number = blk;
        rq.slot         = idx;
        pending_reqs.push_back(rq);
        n_queued++;
    endtask

    // Applies one request to the predicted table and returns the grant it yields.
    function automatic grant_t predict_access(req_t rq);
        grant_t g;
        int     pick;
        g    = '0;
        pick = -1;
        if (rq.cmd == CMD_GET)
        begin
            // tag match ignores the valid mark; lowest index wins
            for (int i = 0; i < ENTRIES; i++)
                if (pick < 0 && tag_dev[i] == rq.device && tag_blk[i] == rq.block_number)
                    pick = i;
            if (pick >= 0)
            begin
                g.hit = 1'b1;
                n_hits++;
                if (ref_cnt[pick] == COUNT_MAX)
                begin
                    g.status = ST_SAT;
                    n_sat++;
                end
                else
                    ref_cnt[pick]++;
            end
            else
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (pick < 0 && ref_cnt[i] == 0)
                        pick = i;
                if (pick < 0)
                begin
                    g.status = ST_NOFREE;
                    n_nofree++;
                    return g;
                end
                tag_dev[pick]   = rq.device;
                tag_blk[pick]   = rq.block_number;
                tag_valid[pick] = 1'b0;
                ref_cnt[pick]   = 8'd1;
            end
            g.slot_out       = 5'(pick);
            g.needs_read     = !tag_valid[pick];
            tag_valid[pick]  = 1'b1;
            return g;
        end
        g.slot_out = rq.slot;
        if (int'(rq.slot) >= ENTRIES)
            return g;
        if (rq.cmd == CMD_PIN)
        begin
            if (ref_cnt[rq.slot] == COUNT_MAX)
            begin
                g.status = ST_SAT;
                n_sat++;
            end
            else
                ref_cnt[rq.slot]++;
        end
        else if (ref_cnt[rq.slot] == 0)
        begin
            g.status = ST_UNDER;
            n_under++;
        end
        else
            ref_cnt[rq.slot]--;
        return g;
    endfunction

    // Driver: predicts each accepted beat, then offers the next pending request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                tag_dev[i]   = '0;
                tag_blk[i]   = '0;
                tag_valid[i] = 1'b0;
                ref_cnt[i]   = '0;
            end
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_grants.push_back(predict_access({cmd, device, block_number, slot}));
                n_accepted <= n_accepted + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_reqs.size() != 0 && (quiet || $urandom_range(0, 99) >= 9))
                begin
                    next_req = pending_reqs.pop_front();
                    in_valid     <= 1'b1;
                    cmd          <= next_req.cmd;
                    device       <= next_req.device;
                    block_number <= next_req.block_number;
                    slot         <= next_req.slot;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, once, while the sender keeps offering beats
    always @(posedge clk)
    begin
        if (!hold_done && n_accepted >= HOLD_AT)
        begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: checks each accepted result against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_grants.size() == 0)
                    report_mismatch("unexpected result, slot_out", slot_out, 0);
                else
                begin
                    want = expected_grants.pop_front();
                    if (slot_out !== want.slot_out)
                        report_mismatch("slot_out", slot_out, want.slot_out);
                    if (hit !== want.hit)
                        report_mismatch("hit", hit, want.hit);
                    if (needs_read !== want.needs_read)
                        report_mismatch("needs_read", needs_read, want.needs_read);
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                end
                n_checked++;
            end
            out_stall <= (hold_left != 0) || (!quiet && $urandom_range(0, 99) < 9);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycles, expected_grants.size());
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || expected_grants.size() != 0);
    endtask

    // Random mix: gets from a small key set (hits), fresh gets (claims), count
    // changes biased to low slots, and now and then a fill-and-drain burst.
    task automatic queue_mixed(int n_items);
        int         start;
        int         kind;
        logic [1:0] op;
        start = n_queued;
        while (n_queued - start < n_items)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 40)
                push_req(CMD_GET, 8'($urandom_range(0, 3)),
                         ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5),
                         5'($urandom));
            else if (kind < 55)
                push_req(CMD_GET, 8'($urandom), $urandom, 5'($urandom));
            else if (kind < 95)
            begin
                case ($urandom_range(0, 2))
                    0:       op = CMD_RELEASE;
                    1:       op = CMD_UNPIN;
                    default: op = CMD_PIN;
                endcase
                push_req(op, 8'($urandom), $urandom,
                         ($urandom_range(0, 1) == 1) ? 5'($urandom_range(0, 7))
                                                     : 5'($urandom));
            end
            else
            begin
                // more fresh tags than entries, so the table runs out
                repeat (ENTRIES + 4)
                    push_req(CMD_GET, 8'($urandom), $urandom, 5'($urandom));
                for (int k = 0; k < ENTRIES; k++)
                    repeat ($urandom_range(1, 4))
                        push_req(($urandom_range(0, 1) == 1) ? CMD_RELEASE : CMD_UNPIN,
                                 8'($urandom), $urandom, 5'(k));
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // after reset every entry is tagged 0/0, so this hits entry 0 with a read
        push_req(CMD_GET, 8'h00, 32'h0000_0000, 5'd0);
        push_req(CMD_GET, 8'h00, 32'h0000_0000, 5'd31);
        push_req(CMD_GET, 8'hFF, 32'hFFFF_FFFF, 5'd31);
        push_req(CMD_GET, 8'hA5, 32'h5A5A_5A5A, 5'd10);
        push_req(CMD_PIN, 8'hFF, 32'hFFFF_FFFF, 5'd31);
        push_req(CMD_GET, 8'h01, 32'h8000_0000, 5'd0);
        push_req(CMD_RELEASE, 8'h00, 32'h0000_0000, 5'd30);
        push_req(CMD_UNPIN, 8'h00, 32'h0000_0000, 5'd31);
        push_req(CMD_UNPIN, 8'h00, 32'h0000_0000, 5'd31);
        push_req(CMD_RELEASE, 8'h00, 32'h0000_0000, 5'd0);
        push_req(CMD_RELEASE, 8'h00, 32'h0000_0000, 5'd0);
        push_req(CMD_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0);
        // entry 0 is free again and gets retagged
        push_req(CMD_GET, 8'h12, 32'h0000_0034, 5'd0);
        // next match for 0/0 is an unused entry: hit, yet the data is not valid
        push_req(CMD_GET, 8'h00, 32'h0000_0000, 5'd0);
        push_req(CMD_PIN, 8'h00, 32'h0000_0000, 5'd16);
        push_req(CMD_PIN, 8'h00, 32'h0000_0000, 5'd16);
        push_req(CMD_UNPIN, 8'h00, 32'h0000_0000, 5'd16);
        push_req(CMD_RELEASE, 8'h00, 32'h0000_0000, 5'd16);
        push_req(CMD_RELEASE, 8'h00, 32'h0000_0000, 5'd16);
        wait_idle();

        queue_mixed(220);
        wait_idle();

        // drive entry 0 into saturation, hit it there, then release it past zero
        repeat (260)
            push_req(CMD_PIN, 8'($urandom), $urandom, 5'd0);
        repeat (2)
            push_req(CMD_GET, tag_dev[0], tag_blk[0], 5'($urandom));
        repeat (262)
            push_req(CMD_RELEASE, 8'($urandom), $urandom, 5'd0);

        queue_mixed(320);
        wait_idle();
        repeat (20) @(posedge clk);

        if (expected_grants.size() != 0)
            report_mismatch("results never seen", expected_grants.size(), 0);
        $display("Ran %0d beats, %0d results checked, %0d mismatches",
                 n_accepted, n_checked, n_errors);
        $display("Covered %0d hits, %0d table-full gets, %0d saturations, %0d underflows",
                 n_hits, n_nofree, n_sat, n_under);
        if (n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
